/* design/assert_macros.svh */
// Assertion helpers included by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define DPB_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define DPB_CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dpb_pkg.sv */
package dpb_pkg;

	localparam int PIX_W          = 11;
	localparam int DEPTH_W        = 16;
	localparam int FIELD_W        = 21;
	localparam int REG_W          = 63;
	localparam int DATA_W         = 64;
	localparam int ADDR_W         = 5;
	localparam int COORD_BITS_DEF = 11;
	// the largest normalized magnitude lands in [2^NORM_POS, 2^(NORM_POS+1))
	localparam int NORM_POS       = 30;
	localparam int MAG_W          = NORM_POS + 1;
	localparam int SQ2_W          = 2 * MAG_W;
	localparam int SQ_W           = 64;
	localparam int DM_W           = DEPTH_W + MAG_W;
	localparam int ROOT_W         = SQ_W / 2;
	localparam int REM_W          = ROOT_W + 2;
	localparam int NUM_W          = DM_W + 2;
	localparam int DEN_W          = ROOT_W + 1;
	localparam int QW             = DEPTH_W;
	localparam int WEXT_W         = FIELD_W + 2;

	localparam logic signed [FIELD_W-1:0] OUT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic signed [FIELD_W-1:0] OUT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_RAY_X,
		REG_RAY_Y,
		REG_RAY_Z,
		REG_ORIGIN
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][REG_W-1:0] ray;
		logic [REG_W-1:0]      origin;
	} cfg_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic               vld;
		logic               zero;
		logic [2:0]         neg;
		logic [DEPTH_W-1:0] depth;
	} ctl_t;

	function automatic logic signed [FIELD_W-1:0] field_of(input logic [REG_W-1:0] r,
			input int unsigned slot);
		return $signed(r[slot*FIELD_W +: FIELD_W]);
	endfunction

endpackage

/* design/dpb_pix_if.sv */
interface dpb_pix_if import dpb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   pixel_col;
	logic [PIX_W-1:0]   pixel_row;
	logic [DEPTH_W-1:0] depth_cm;

	modport source (output valid, pixel_col, pixel_row, depth_cm, input ready);
	modport sink (input valid, pixel_col, pixel_row, depth_cm, output ready);
endinterface

/* design/dpb_pt_if.sv */
interface dpb_pt_if import dpb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] world_x;
	logic signed [FIELD_W-1:0] world_y;
	logic signed [FIELD_W-1:0] world_z;

	modport source (output valid, world_x, world_y, world_z, input ready);
	modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

/* design/depth_pixel_backprojection_core.sv */
// Channel   Dir   Payload                           Transaction
// pix       in    pixel_col, pixel_row, depth_cm    valid && ready
// pt        out   world_x, world_y, world_z         valid && ready
// apb       in    63-bit registers at 8*i           psel && penable && pwrite
//
// One pixel per cycle while pt does not stall; 6 ray/normalize stages,
// 32 square-root stages (one root bit each), 17 divider stages, 1 output register.
// Asynchronous active-low reset clears valid bits and the configuration registers.
// A stall at pt freezes the whole pipeline in place; pix.ready drops with it.
`include "assert_macros.svh"

module depth_pixel_backprojection_core import dpb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	dpb_pix_if.sink           pix,
	dpb_pt_if.source          pt
);

	cfg_t              cfg;
	logic              en;
	ctl_t              ctl_in, ctl_a, ctl_r, ctl_d;
	logic [SQ_W-1:0]   sum_a;
	logic [DM_W-1:0]   dm_a [3];
	logic [DM_W-1:0]   dm_r [3];
	logic [ROOT_W-1:0] root_r;
	logic [QW-1:0]     q_d [3];

	logic signed [QW:0]         qs_c  [3];
	logic signed [WEXT_W-1:0]   w_c   [3];
	logic signed [FIELD_W-1:0]  sat_c [3];
	logic                       out_vld_q;
	logic signed [FIELD_W-1:0]  out_q [3];

	// global advance: output register empty or being drained
	assign en        = !out_vld_q || pt.ready;
	assign pix.ready = en;

	assign ctl_in = '{vld: pix.valid, zero: 1'b0, neg: 3'b000, depth: pix.depth_cm};

	dpb_apb_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	dpb_ray #(.COORD_BITS(COORD_BITS)) u_ray (
		.clk, .arst_n, .en,
		.ctl_i (ctl_in),
		.col   (pix.pixel_col),
		.row   (pix.pixel_row),
		.cfg,
		.ctl_o (ctl_a),
		.sum_o (sum_a),
		.dm_o  (dm_a)
	);

	dpb_isqrt u_sqrt (
		.clk, .arst_n, .en,
		.ctl_i  (ctl_a),
		.sum_i  (sum_a),
		.dm_i   (dm_a),
		.ctl_o  (ctl_r),
		.root_o (root_r),
		.dm_o   (dm_r)
	);

	dpb_div u_div (
		.clk, .arst_n, .en,
		.ctl_i  (ctl_r),
		.root_i (root_r),
		.dm_i   (dm_r),
		.ctl_o  (ctl_d),
		.q_o    (q_d)
	);

	// sign, origin offset, saturation
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl_d.zero) begin
				qs_c[i] = '0;
			end else if (ctl_d.neg[i]) begin
				qs_c[i] = -$signed({1'b0, q_d[i]});
			end else begin
				qs_c[i] = $signed({1'b0, q_d[i]});
			end
			w_c[i] = WEXT_W'(field_of(cfg.origin, i)) + WEXT_W'(qs_c[i]);
			if (w_c[i] > WEXT_W'(OUT_MAX)) begin
				sat_c[i] = OUT_MAX;
			end else if (w_c[i] < WEXT_W'(OUT_MIN)) begin
				sat_c[i] = OUT_MIN;
			end else begin
				sat_c[i] = FIELD_W'(w_c[i]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ctl_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= sat_c;
		end
	end

	assign pt.valid   = out_vld_q;
	assign pt.world_x = out_q[0];
	assign pt.world_y = out_q[1];
	assign pt.world_z = out_q[2];

	`DPB_CHK_ALWAYS(a_stall_blocks_input, (pt.valid && !pt.ready) |-> !pix.ready, "input taken during output stall")
	`DPB_CHK(a_root_normalized, (ctl_r.vld && !ctl_r.zero) |-> (root_r[ROOT_W-1:ROOT_W-2] != 2'b00), "ray norm not normalized")
	`DPB_CHK(a_offset_le_depth, (ctl_d.vld && !ctl_d.zero) |-> (q_d[0] <= ctl_d.depth && q_d[1] <= ctl_d.depth && q_d[2] <= ctl_d.depth), "offset exceeds depth")

endmodule

/* design/dpb_apb_regs.sv */
module dpb_apb_regs import dpb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_RAY_X:  cfg.ray[0] <= pwdata[REG_W-1:0];
				REG_RAY_Y:  cfg.ray[1] <= pwdata[REG_W-1:0];
				REG_RAY_Z:  cfg.ray[2] <= pwdata[REG_W-1:0];
				REG_ORIGIN: cfg.origin <= pwdata[REG_W-1:0];
				default:    cfg.origin <= cfg.origin;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_RAY_X:  prdata = {1'b0, cfg.ray[0]};
			REG_RAY_Y:  prdata = {1'b0, cfg.ray[1]};
			REG_RAY_Z:  prdata = {1'b0, cfg.ray[2]};
			REG_ORIGIN: prdata = {1'b0, cfg.origin};
			default:    prdata = '0;
		endcase
	end

endmodule

/* design/dpb_ray.sv */
// Ray product, normalization, squares: six stages.
module dpb_ray import dpb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl_i,
	input  logic [PIX_W-1:0] col,
	input  logic [PIX_W-1:0] row,
	input  cfg_t             cfg,
	output ctl_t             ctl_o,
	output logic [SQ_W-1:0]  sum_o,
	output logic [DM_W-1:0]  dm_o [3]
);

	localparam int CW = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
	localparam int PW = FIELD_W + CW + 1;
	localparam int RW = FIELD_W + CW + 3;
	localparam int LW = $clog2(RW);

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic signed [PW-1:0]      pa_s1 [3];
	logic signed [PW-1:0]      pb_s1 [3];
	logic signed [FIELD_W-1:0] c_s1  [3];
	logic [RW-1:0]             mag_s2 [3];
	logic [RW-1:0]             mag_s3 [3];
	logic [LW-1:0]             lead_s3;
	logic [MAG_W-1:0]          mag_s4 [3];
	logic [SQ2_W-1:0]          sq_s5 [3];
	logic [DM_W-1:0]           dm_s5 [3];
	logic [SQ_W-1:0]           sum_s6;
	logic [DM_W-1:0]           dm_s6 [3];

	logic signed [RW-1:0] r_c [3];
	logic [RW-1:0]        mag_c [3];
	logic [2:0]           neg_c;
	logic [RW-1:0]        or_c;
	logic [LW-1:0]        lead_c;
	logic [MAG_W-1:0]     nrm_c [3];

	// ray components and magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_c[i]   = RW'(pa_s1[i]) + RW'(pb_s1[i]) + RW'(c_s1[i]);
			neg_c[i] = r_c[i][RW-1];
			mag_c[i] = neg_c[i] ? RW'(-r_c[i]) : RW'(r_c[i]);
		end
	end

	// leading one of the largest magnitude equals that of the OR
	always_comb begin
		or_c   = mag_s2[0] | mag_s2[1] | mag_s2[2];
		lead_c = '0;
		for (int b = 0; b < RW; b++) begin
			if (or_c[b]) lead_c = LW'(b);
		end
	end

	// common normalizing shift
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lead_s3 >= LW'(NORM_POS)) begin
				nrm_c[i] = MAG_W'(mag_s3[i] >> (lead_s3 - LW'(NORM_POS)));
			end else begin
				nrm_c[i] = MAG_W'(mag_s3[i] << (LW'(NORM_POS) - lead_s3));
			end
		end
	end

	// control path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s1      <= ctl_i;
			ctl_s2      <= ctl_s1;
			ctl_s2.neg  <= neg_c;
			ctl_s3      <= ctl_s2;
			ctl_s3.zero <= (or_c == '0);
			ctl_s4      <= ctl_s3;
			ctl_s5      <= ctl_s4;
			ctl_s6      <= ctl_s5;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= field_of(cfg.ray[i], 0) * $signed({1'b0, col[CW-1:0]});
				pb_s1[i] <= field_of(cfg.ray[i], 1) * $signed({1'b0, row[CW-1:0]});
				c_s1[i]  <= field_of(cfg.ray[i], 2);
				mag_s2[i] <= mag_c[i];
				mag_s3[i] <= mag_s2[i];
				mag_s4[i] <= nrm_c[i];
				sq_s5[i]  <= mag_s4[i] * mag_s4[i];
				dm_s5[i]  <= ctl_s4.depth * mag_s4[i];
				dm_s6[i]  <= dm_s5[i];
			end
			lead_s3 <= lead_c;
			sum_s6  <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2]);
		end
	end

	assign ctl_o = ctl_s6;
	assign sum_o = sum_s6;
	assign dm_o  = dm_s6;

endmodule

/* design/dpb_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module dpb_isqrt import dpb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ctl_t              ctl_i,
	input  logic [SQ_W-1:0]   sum_i,
	input  logic [DM_W-1:0]   dm_i [3],
	output ctl_t              ctl_o,
	output logic [ROOT_W-1:0] root_o,
	output logic [DM_W-1:0]   dm_o [3]
);

	ctl_t              ctl_s  [ROOT_W];
	logic [SQ_W-1:0]   sum_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [DM_W-1:0]   dm_s   [ROOT_W][3];

	logic [SQ_W-1:0]   sum_p  [ROOT_W];
	logic [ROOT_W-1:0] root_p [ROOT_W];
	logic [REM_W-1:0]  rem_p  [ROOT_W];
	logic [REM_W-1:0]  rem_t  [ROOT_W];
	logic [REM_W-1:0]  trial  [ROOT_W];

	// bring down two radicand bits, try setting the next root bit
	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				sum_p[k]  = sum_i;
				root_p[k] = '0;
				rem_p[k]  = '0;
			end else begin
				sum_p[k]  = sum_s[k-1];
				root_p[k] = root_s[k-1];
				rem_p[k]  = rem_s[k-1];
			end
			rem_t[k] = {rem_p[k][REM_W-3:0], sum_p[k][SQ_W-1-2*k -: 2]};
			trial[k] = {root_p[k], 2'b01};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++) ctl_s[k] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_i;
			for (int k = 1; k < ROOT_W; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) dm_s[0][i] <= dm_i[i];
			for (int k = 1; k < ROOT_W; k++) begin
				for (int i = 0; i < 3; i++) dm_s[k][i] <= dm_s[k-1][i];
			end
			for (int k = 0; k < ROOT_W; k++) begin
				sum_s[k] <= sum_p[k];
				if (rem_t[k] >= trial[k]) begin
					rem_s[k]  <= rem_t[k] - trial[k];
					root_s[k] <= {root_p[k][ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_t[k];
					root_s[k] <= {root_p[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign ctl_o  = ctl_s[ROOT_W-1];
	assign root_o = root_s[ROOT_W-1];
	assign dm_o   = dm_s[ROOT_W-1];

endmodule

/* design/dpb_div.sv */
// Rounded quotient (2*d*m + n) / (2*n), one quotient bit per stage, three lanes.
module dpb_div import dpb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ctl_t              ctl_i,
	input  logic [ROOT_W-1:0] root_i,
	input  logic [DM_W-1:0]   dm_i [3],
	output ctl_t              ctl_o,
	output logic [QW-1:0]     q_o [3]
);

	ctl_t             ctl_s [QW+1];
	logic [DEN_W-1:0] den_s [QW+1];
	logic [NUM_W-1:0] rem_s [QW+1][3];
	logic [QW-1:0]    q_s   [QW+1][3];

	logic [NUM_W-1:0] cmp [QW];
	logic             ge  [QW][3];

	// stage j+1 tests divisor shifted by QW-1-j
	always_comb begin
		for (int j = 0; j < QW; j++) begin
			cmp[j] = NUM_W'(den_s[j]) << (QW - 1 - j);
			for (int i = 0; i < 3; i++) ge[j][i] = rem_s[j][i] >= cmp[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QW; j++) ctl_s[j] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_i;
			for (int j = 1; j <= QW; j++) ctl_s[j] <= ctl_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// numerator and divisor setup
			den_s[0] <= {root_i, 1'b0};
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= {dm_i[i], 1'b0} + NUM_W'(root_i);
				q_s[0][i]   <= '0;
			end
			// restoring steps
			for (int j = 0; j < QW; j++) begin
				den_s[j+1] <= den_s[j];
				for (int i = 0; i < 3; i++) begin
					rem_s[j+1][i] <= ge[j][i] ? rem_s[j][i] - cmp[j] : rem_s[j][i];
					q_s[j+1][i]   <= {q_s[j][i][QW-2:0], ge[j][i]};
				end
			end
		end
	end

	assign ctl_o = ctl_s[QW];
	assign q_o   = q_s[QW];

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import dpb_pkg::*;

	typedef struct {
		logic [PIX_W-1:0]   col;
		logic [PIX_W-1:0]   row;
		logic [DEPTH_W-1:0] depth;
	} pixel_t;

	typedef struct {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
	} point_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	dpb_pix_if pix ();
	dpb_pt_if  pt ();

	depth_pixel_backprojection_core i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix(pix.sink), .pt(pt.source)
	);

	// shadow copy of the ray matrix and origin
	logic [REG_W-1:0] ray_reg [3];
	logic [REG_W-1:0] origin_reg;

	pixel_t pending_px[$];
	point_t exp_pts[$];
	int     idle_pct = 29;
	bit     send_pause = 1'b0;
	int     hold_reqs = 0;
	int     hold_seen = 0;
	int     hold_cnt = 0;
	int     errs = 0;
	int     n_pts = 0;
	int     n_cfg = 0;

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint coef(input logic [REG_W-1:0] r, input int slot);
		logic signed [FIELD_W-1:0] f;
		f = r[slot*FIELD_W +: FIELD_W];
		return longint'(f);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [FIELD_W-1:0] clamp_field(input longint v);
		if (v > 1048575) return OUT_MAX;
		if (v < -1048576) return OUT_MIN;
		return v[FIELD_W-1:0];
	endfunction

	// back-project one pixel with the shadow configuration
	function automatic point_t project_pixel(input pixel_t p);
		longint      r;
		longint      q;
		logic [63:0] mag [3];
		bit          neg [3];
		logic [63:0] mx;
		logic [63:0] sum;
		logic [63:0] n;
		logic [63:0] u;
		logic signed [FIELD_W-1:0] w [3];
		point_t      res;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			r = coef(ray_reg[i], 0) * longint'(p.col) + coef(ray_reg[i], 1) * longint'(p.row)
				+ coef(ray_reg[i], 2);
			neg[i] = r < 0;
			mag[i] = neg[i] ? 64'(-r) : 64'(r);
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx != 0) begin
			while (mx >= (64'd1 << 31)) begin
				mx = mx >> 1;
				for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
			end
			while (mx < (64'd1 << 30)) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
			end
		end
		sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		n = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = 0;
			if (n != 0) begin
				u = (64'd2 * 64'(p.depth) * mag[i] + n) / (64'd2 * n);
				q = neg[i] ? -longint'(u) : longint'(u);
			end
			w[i] = clamp_field(coef(origin_reg, i) + q);
		end
		res.x = w[0];
		res.y = w[1];
		res.z = w[2];
		return res;
	endfunction

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.pixel_col <= '0;
			pix.pixel_row <= '0;
			pix.depth_cm <= '0;
		end else if (!(pix.valid && !pix.ready)) begin
			if (pix.valid && pix.ready) begin
				exp_pts.push_back(project_pixel(pending_px[0]));
				void'(pending_px.pop_front());
			end
			if (pending_px.size() > 0 && !send_pause && $urandom_range(99) >= idle_pct) begin
				pix.valid <= 1'b1;
				pix.pixel_col <= pending_px[0].col;
				pix.pixel_row <= pending_px[0].row;
				pix.depth_cm <= pending_px[0].depth;
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// point monitor and checker
	always @(posedge clk or negedge arst_n) begin
		point_t e;
		if (!arst_n) begin
			pt.ready <= 1'b0;
		end else begin
			if (pt.valid && pt.ready) begin
				n_pts++;
				if (exp_pts.size() == 0) begin
					$error("unexpected point transaction");
					errs++;
				end else begin
					e = exp_pts.pop_front();
					if (pt.world_x !== e.x) begin
						$error("world_x expected %0d actual %0d", e.x, pt.world_x);
						errs++;
					end
					if (pt.world_y !== e.y) begin
						$error("world_y expected %0d actual %0d", e.y, pt.world_y);
						errs++;
					end
					if (pt.world_z !== e.z) begin
						$error("world_z expected %0d actual %0d", e.z, pt.world_z);
						errs++;
					end
				end
			end
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pt.ready <= 1'b0;
			end else begin
				pt.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(8 * int'(idx));
		pwdata <= {1'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_ORIGIN) origin_reg = val;
		else ray_reg[idx] = val;
		n_cfg++;
	endtask

	function automatic logic [FIELD_W-1:0] rand_coef(input int mode);
		case (mode)
			0: return OUT_MAX;
			1: return OUT_MIN;
			2: return FIELD_W'($urandom);
			default: return FIELD_W'($urandom_range(2048) - 1024);
		endcase
	endfunction

	task automatic load_config(input int mode);
		logic [REG_W-1:0] v;
		for (int i = 0; i < 4; i++) begin
			v = {rand_coef(mode), rand_coef(mode), rand_coef(mode)};
			if (mode > 2 && i < 3 && $urandom_range(3) == 0) v = '0;
			reg_write(reg_idx_t'(i), v);
		end
	endtask

	task automatic push_px(input int c, input int r, input int d);
		pixel_t p;
		p.col = PIX_W'(c);
		p.row = PIX_W'(r);
		p.depth = DEPTH_W'(d);
		pending_px.push_back(p);
	endtask

	// wait until the pipeline is empty before touching registers
	task automatic drain();
		wait (pending_px.size() == 0 && exp_pts.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		int d;
		for (int i = 0; i < 3; i++) ray_reg[i] = '0;
		origin_reg = '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// zero ray after reset: origin comes back
		push_px(0, 0, 0);
		push_px(2047, 2047, 65535);
		push_px(1024, 5, 300);
		drain();

		// directed corners under extreme and typical matrices
		for (int m = 0; m < 4; m++) begin
			load_config(m);
			push_px(0, 0, 65535);
			push_px(2047, 0, 1);
			push_px(0, 2047, 32768);
			push_px(2047, 2047, 0);
			push_px(1023, 1024, 65535);
			drain();
		end

		// random phases
		for (int ph = 0; ph < 11; ph++) begin
			load_config(ph % 6 == 0 ? $urandom_range(1) : 2 + $urandom_range(1));
			idle_pct = (ph == 3) ? 0 : 29;
			if (ph == 5) hold_reqs++;
			for (int k = 0; k < 80; k++) begin
				d = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2000);
				push_px($urandom_range(2047), $urandom_range(2047), d);
				if (ph == 7 && k == 40) begin
					// sender goes quiet until every result is back
					wait (pending_px.size() == 0);
					send_pause = 1'b1;
					wait (exp_pts.size() == 0);
					repeat (20) @(posedge clk);
					send_pause = 1'b0;
				end
			end
			send_pause = 1'b0;
			drain();
		end

		$display("Checked %0d world points over %0d register writes,", n_pts, n_cfg);
		$display("with extreme matrices, zero rays, zero depth and back-pressure.");
		if (errs == 0 && exp_pts.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
